/* design/bls_pkg.sv */
// ----------------------------------------------------------------------------
// bls_pkg
// Shared constants and helpers for the line stepper: default sizes,
// command codes and the width of a decoded command packet.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int COLOR_BITS      = 32;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // command, start x/y, major target, |dx|, |dy|, four flags, color
    function automatic int packet_bits(input int coord_bits);
        return 1 + 3 * coord_bits + 2 * (coord_bits + 1) + 4 + COLOR_BITS;
    endfunction

endpackage

/* design/bresenham_line_stepper.sv */
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Integer line generator: start commands load a line, step commands return
// its pixels one at a time.
// ----------------------------------------------------------------------------
// Commands go in through push/full, pixels come out through empty/pop. A
// start command (command 0) loads both endpoints and the color and returns
// nothing; each step command (command 1) returns the next pixel of the line,
// with last_pixel set on the final one. The end point is not drawn, a
// zero-length line and a step while idle return nothing, and a start drops
// any line in progress. The block takes one command per cycle while the
// queue is not full and returns one pixel per cycle while the consumer pops;
// a step passes through the command queue and the output register first.
// The command queue holds QUEUE_DEPTH commands, so push keeps flowing
// while the consumer stalls until that queue fills.
module bresenham_line_stepper #(
    parameter int COORD_BITS  = bls_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = bls_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_command,
    input  logic signed [COORD_BITS-1:0]   i_start_x,
    input  logic signed [COORD_BITS-1:0]   i_start_y,
    input  logic signed [COORD_BITS-1:0]   i_end_x,
    input  logic signed [COORD_BITS-1:0]   i_end_y,
    input  logic [bls_pkg::COLOR_BITS-1:0] i_line_color,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [COORD_BITS-1:0]   o_pixel_x,
    output logic signed [COORD_BITS-1:0]   o_pixel_y,
    output logic [bls_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                           o_last_pixel
);

    localparam int PKT_BITS = bls_pkg::packet_bits(COORD_BITS);

    logic [PKT_BITS-1:0] front_packet;
    logic [PKT_BITS-1:0] q_data;
    logic                q_valid;
    logic                q_take;
    logic                out_valid;

    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_command    (i_command),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_line_color (i_line_color),
        .o_packet     (front_packet)
    );

    bls_queue #(
        .DATA_BITS (PKT_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (front_packet),
        .o_full    (full),
        .i_rd      (q_take),
        .o_valid   (q_valid),
        .o_rd_data (q_data)
    );

    bls_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd_data    (q_data),
        .o_cmd_take    (q_take),
        .o_out_valid   (out_valid),
        .i_out_pop     (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

    assign empty = !out_valid;

endmodule

/* design/bls_front.sv */
// ----------------------------------------------------------------------------
// bls_front
// Command decode: turns a start command into the deltas, directions,
// major axis and major-axis target of the line, packed for the queue.
// ----------------------------------------------------------------------------
module bls_front #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
    localparam int PKT_BITS  = bls_pkg::packet_bits(COORD_BITS)
) (
    input  logic                              i_command,
    input  logic signed [COORD_BITS-1:0]      i_start_x,
    input  logic signed [COORD_BITS-1:0]      i_start_y,
    input  logic signed [COORD_BITS-1:0]      i_end_x,
    input  logic signed [COORD_BITS-1:0]      i_end_y,
    input  logic [bls_pkg::COLOR_BITS-1:0]    i_line_color,
    output logic [PKT_BITS-1:0]               o_packet
);

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic        [COORD_BITS:0]   abs_dx;
    logic        [COORD_BITS:0]   abs_dy;
    logic                         x_dir_neg;
    logic                         y_dir_neg;
    logic                         x_major;
    logic                         active;
    logic signed [COORD_BITS-1:0] target;

    always_comb begin
        dx        = (COORD_BITS + 1)'(i_end_x) - (COORD_BITS + 1)'(i_start_x);
        dy        = (COORD_BITS + 1)'(i_end_y) - (COORD_BITS + 1)'(i_start_y);
        x_dir_neg = (dx <= 0);
        y_dir_neg = (dy <= 0);
        abs_dx    = dx[COORD_BITS] ? (COORD_BITS + 1)'(-dx) : (COORD_BITS + 1)'(dx);
        abs_dy    = dy[COORD_BITS] ? (COORD_BITS + 1)'(-dy) : (COORD_BITS + 1)'(dy);
        x_major   = (abs_dx > abs_dy);
        target    = x_major ? i_end_x : i_end_y;
        // a zero-length major axis leaves the stepper idle
        active    = x_major ? (i_start_x != i_end_x) : (i_start_y != i_end_y);
    end

    assign o_packet = {i_command, i_start_x, i_start_y, target, abs_dx, abs_dy,
                       x_dir_neg, y_dir_neg, x_major, active, i_line_color};

endmodule

/* design/bls_queue.sv */
// ----------------------------------------------------------------------------
// bls_queue
// Small first-in first-out queue of decoded commands between the decode
// and the stepper.
// ----------------------------------------------------------------------------
module bls_queue #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = bls_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    output logic                 o_full,
    input  logic                 i_rd,
    output logic                 o_valid,
    output logic [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr;
    logic [CNT_BITS-1:0]  r_count;
    logic                 wr_en;
    logic                 rd_en;

    assign o_full    = (r_count == CNT_BITS'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && o_valid;
    assign o_rd_data = r_mem[r_rd_ptr];

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (rd_en) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

endmodule

/* design/bls_back.sv */
// ----------------------------------------------------------------------------
// bls_back
// Stepper: loads line state on a start command and produces one pixel per
// step command while a line is active, into an output register.
// ----------------------------------------------------------------------------
module bls_back #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
    localparam int PKT_BITS  = bls_pkg::packet_bits(COORD_BITS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  logic [PKT_BITS-1:0]            i_cmd_data,
    output logic                           o_cmd_take,
    output logic                           o_out_valid,
    input  logic                           i_out_pop,
    output logic signed [COORD_BITS-1:0]   o_pixel_x,
    output logic signed [COORD_BITS-1:0]   o_pixel_y,
    output logic [bls_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                           o_last_pixel
);

    localparam int C = COORD_BITS;

    // head of the queue
    logic                           h_cmd;
    logic [C-1:0]                   h_sx;
    logic [C-1:0]                   h_sy;
    logic [C-1:0]                   h_target;
    logic [C:0]                     h_abs_dx;
    logic [C:0]                     h_abs_dy;
    logic                           h_xn;
    logic                           h_yn;
    logic                           h_xm;
    logic                           h_active;
    logic [bls_pkg::COLOR_BITS-1:0] h_color;

    // line state
    logic [C-1:0]                   r_cur_x;
    logic [C-1:0]                   r_cur_y;
    logic [C-1:0]                   r_target;
    logic [C:0]                     r_abs_dx;
    logic [C:0]                     r_abs_dy;
    logic signed [C+1:0]            r_err;
    logic                           r_xn;
    logic                           r_yn;
    logic                           r_xm;
    logic                           r_active;
    logic [bls_pkg::COLOR_BITS-1:0] r_color;

    // output register
    logic                           r_out_valid;
    logic [C-1:0]                   r_out_x;
    logic [C-1:0]                   r_out_y;
    logic [bls_pkg::COLOR_BITS-1:0] r_out_color;
    logic                           r_out_last;

    logic                           out_ready;
    logic                           is_step;
    logic                           emit;
    logic [C:0]                     minor;
    logic [C:0]                     major;
    logic signed [C+2:0]            e1;
    logic signed [C+2:0]            e2;
    logic                           move_minor;
    logic [C-1:0]                   n_x;
    logic [C-1:0]                   n_y;
    logic signed [C+1:0]            n_err;
    logic                           n_active;

    assign {h_cmd, h_sx, h_sy, h_target, h_abs_dx, h_abs_dy,
            h_xn, h_yn, h_xm, h_active, h_color} = i_cmd_data;

    assign out_ready  = !r_out_valid || i_out_pop;
    assign is_step    = (h_cmd == bls_pkg::CMD_STEP);
    // a step while idle is consumed without a result
    assign o_cmd_take = i_cmd_valid && (!is_step || !r_active || out_ready);
    assign emit       = o_cmd_take && is_step && r_active;

    always_comb begin
        minor      = r_xm ? r_abs_dy : r_abs_dx;
        major      = r_xm ? r_abs_dx : r_abs_dy;
        e1         = (C + 3)'(r_err) + $signed({2'b00, minor});
        e2         = e1 - $signed({2'b00, major});
        move_minor = ((e1 <<< 1) >= $signed({2'b00, major}));
        n_err      = move_minor ? e2[C+1:0] : e1[C+1:0];
        n_x        = r_cur_x;
        n_y        = r_cur_y;
        if (r_xm || move_minor) begin
            n_x = r_xn ? r_cur_x - C'(1) : r_cur_x + C'(1);
        end
        if (!r_xm || move_minor) begin
            n_y = r_yn ? r_cur_y - C'(1) : r_cur_y + C'(1);
        end
        n_active = r_xm ? (n_x != r_target) : (n_y != r_target);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_take && !is_step) begin
                r_active <= h_active;
            end else if (emit) begin
                r_active <= n_active;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take && !is_step) begin
            r_cur_x  <= h_sx;
            r_cur_y  <= h_sy;
            r_target <= h_target;
            r_abs_dx <= h_abs_dx;
            r_abs_dy <= h_abs_dy;
            r_err    <= '0;
            r_xn     <= h_xn;
            r_yn     <= h_yn;
            r_xm     <= h_xm;
            r_color  <= h_color;
        end else if (emit) begin
            r_cur_x <= n_x;
            r_cur_y <= n_y;
            r_err   <= n_err;
        end
        if (emit) begin
            r_out_x     <= r_cur_x;
            r_out_y     <= r_cur_y;
            r_out_color <= r_color;
            r_out_last  <= !n_active;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

endmodule
